@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset.
`define AST_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define AST_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define AST_IMP(name, clk, rstn, ante, cons)
`define AST_NEXT(name, clk, rstn, ante, cons)

`endif

`endif

@@ sv/srt_pkg.sv @@
// ----------------------------------------------------------------------------
// Scheduler package
// Field widths, codes and shared types of the shortest-remaining-time
// scheduler.
// ----------------------------------------------------------------------------
package srt_pkg;

    // Default sizes.
    localparam int MAX_PROCS_DEF = 16;
    localparam int TIME_BITS_DEF = 16;

    // Field widths of the input and result items.
    localparam int KIND_W   = 2;
    localparam int ARR_W    = 16;
    localparam int BURST_W  = 16;
    localparam int STATUS_W = 3;
    localparam int TICK_W   = 16;
    localparam int ID_W     = 5;
    localparam int START_W  = 16;
    localparam int END_W    = 17;
    localparam int TA_W     = 17;
    localparam int WAIT_W   = 16;
    localparam int DONE_W   = 5;
    localparam int SUM_W    = 21;

    // Item kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD  = 2'd0,
        KIND_TICK  = 2'd1,
        KIND_CLEAR = 2'd2
    } t_kind;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_LOADED    = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_RAN       = 3'd2,
        STAT_IDLE      = 3'd3,
        STAT_CLEARED   = 3'd4,
        STAT_EXHAUSTED = 3'd5
    } t_status;

    // Commands broadcast to the cell row.
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_LOAD  = 2'd1,
        OP_RUN   = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [ARR_W-1:0]   arr;
        logic [BURST_W-1:0] burst;
    } t_cmd;

    // Best candidate so far, passed from cell to cell.
    typedef struct packed {
        logic               vld;
        logic [BURST_W-1:0] rem;
        logic [ARR_W-1:0]   arr;
        logic [BURST_W-1:0] burst;
        logic               started;
    } t_cand;

    // One result item.
    typedef struct packed {
        t_status             status;
        logic [TICK_W-1:0]   tick_time;
        logic [ID_W-1:0]     proc_id;
        logic                switched;
        logic                finished;
        logic [START_W-1:0]  start_time;
        logic [END_W-1:0]    end_time;
        logic [TA_W-1:0]     turnaround;
        logic [WAIT_W-1:0]   waiting;
        logic [DONE_W-1:0]   completed_count;
        logic [SUM_W-1:0]    total_turnaround;
        logic [SUM_W-1:0]    total_waiting;
    } t_result;

endpackage

@@ sv/srt_in_if.sv @@
// ----------------------------------------------------------------------------
// Scheduler input channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface srt_in_if;
    logic                         valid;
    logic                         ready;
    logic [srt_pkg::KIND_W-1:0]   kind;
    logic [srt_pkg::ARR_W-1:0]    arrival_time;
    logic [srt_pkg::BURST_W-1:0]  burst_length;

    modport source (output valid, kind, arrival_time, burst_length, input ready);
    modport sink   (input valid, kind, arrival_time, burst_length, output ready);
endinterface

@@ sv/srt_out_if.sv @@
// ----------------------------------------------------------------------------
// Scheduler result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface srt_out_if;
    logic                          valid;
    logic                          ready;
    logic [srt_pkg::STATUS_W-1:0]  status;
    logic [srt_pkg::TICK_W-1:0]    tick_time;
    logic [srt_pkg::ID_W-1:0]      proc_id;
    logic                          switched;
    logic                          finished;
    logic [srt_pkg::START_W-1:0]   start_time;
    logic [srt_pkg::END_W-1:0]     end_time;
    logic [srt_pkg::TA_W-1:0]      turnaround;
    logic [srt_pkg::WAIT_W-1:0]    waiting;
    logic [srt_pkg::DONE_W-1:0]    completed_count;
    logic [srt_pkg::SUM_W-1:0]     total_turnaround;
    logic [srt_pkg::SUM_W-1:0]     total_waiting;

    modport source (
        output valid, status, tick_time, proc_id, switched, finished, start_time,
               end_time, turnaround, waiting, completed_count, total_turnaround,
               total_waiting,
        input  ready
    );
    modport sink (
        input  valid, status, tick_time, proc_id, switched, finished, start_time,
               end_time, turnaround, waiting, completed_count, total_turnaround,
               total_waiting,
        output ready
    );
endinterface

@@ sv/srt_cell.sv @@
// ----------------------------------------------------------------------------
// Scheduler cell
// Holds one process slot and compares it against the candidate handed in by
// the previous cell, passing the better one on to the next cell.
// ----------------------------------------------------------------------------
module srt_cell #(
    parameter int MAX_PROCS = srt_pkg::MAX_PROCS_DEF,
    parameter int TIME_BITS = srt_pkg::TIME_BITS_DEF,
    parameter int INDEX     = 0,
    localparam int IDX_W    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  srt_pkg::t_cmd         i_cmd,
    input  logic [IDX_W-1:0]      i_cmd_idx,
    input  logic [TIME_BITS-1:0]  i_now,
    input  srt_pkg::t_cand        i_cand,
    input  logic [IDX_W-1:0]      i_cand_id,
    input  logic [TIME_BITS-1:0]  i_cand_start,
    output srt_pkg::t_cand        o_cand,
    output logic [IDX_W-1:0]      o_cand_id,
    output logic [TIME_BITS-1:0]  o_cand_start
);
    import srt_pkg::*;

    localparam int CMP_W = (TIME_BITS > ARR_W) ? TIME_BITS : ARR_W;

    logic                 r_vld;
    logic                 r_started;
    logic [ARR_W-1:0]     r_arr;
    logic [BURST_W-1:0]   r_burst;
    logic [BURST_W-1:0]   r_rem;
    logic [TIME_BITS-1:0] r_start;
    t_cand                r_cand;
    logic [IDX_W-1:0]     r_cand_id;
    logic [TIME_BITS-1:0] r_cand_start;

    logic  w_hit;
    logic  w_ready;
    logic  w_take;
    t_cand w_own;

    assign w_hit = (i_cmd_idx == IDX_W'(INDEX));

    // Slot flags, cleared by reset and by a clear command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= 1'b0;
            r_started <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_CLEAR: begin
                    r_vld     <= 1'b0;
                    r_started <= 1'b0;
                end
                OP_LOAD: begin
                    if (w_hit) begin
                        r_vld     <= 1'b1;
                        r_started <= 1'b0;
                    end
                end
                OP_RUN: begin
                    if (w_hit) begin
                        r_started <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Slot payload: written on load, updated when this slot runs.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                if (w_hit) begin
                    r_arr   <= i_cmd.arr;
                    r_burst <= i_cmd.burst;
                    r_rem   <= i_cmd.burst;
                end
            end
            OP_RUN: begin
                if (w_hit) begin
                    r_rem <= r_rem - BURST_W'(1);
                    if (!r_started) begin
                        r_start <= i_now;
                    end
                end
            end
            default: ;
        endcase
    end

    // A slot competes once it has arrived and still has work left. A tie on
    // remaining work goes to the earlier arrival, then to the lower slot.
    assign w_ready = r_vld && (r_rem != '0) && (CMP_W'(r_arr) <= CMP_W'(i_now));
    assign w_take  = w_ready && (!i_cand.vld || (r_rem < i_cand.rem) ||
                     ((r_rem == i_cand.rem) && (r_arr < i_cand.arr)));

    always_comb begin
        w_own.vld     = 1'b1;
        w_own.rem     = r_rem;
        w_own.arr     = r_arr;
        w_own.burst   = r_burst;
        w_own.started = r_started;
    end

    // Candidate stage toward the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand <= '0;
        end else begin
            r_cand <= w_take ? w_own : i_cand;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand_id    <= w_take ? IDX_W'(INDEX) : i_cand_id;
        r_cand_start <= w_take ? r_start : i_cand_start;
    end

    assign o_cand       = r_cand;
    assign o_cand_id    = r_cand_id;
    assign o_cand_start = r_cand_start;

endmodule

@@ sv/shortest_remaining_time_scheduler.sv @@
// ----------------------------------------------------------------------------
// Shortest-remaining-time scheduler
// Preemptive scheduler over a row of process cells with running totals.
// ----------------------------------------------------------------------------
// Each process lives in one cell of a row of MAX_PROCS cells. A tick sweeps
// the best candidate down the row, one cell per clock, so the time a tick
// takes grows with the length of the cell row; load, clear and unknown
// items skip the search state and go straight to apply, calc and finish.
// The result sits in an output register, so a new item can be taken while
// the previous result still waits. Slot contents need no clearing pass:
// only per-slot valid flags are reset.
`include "assert_macros.svh"

module shortest_remaining_time_scheduler #(
    parameter int MAX_PROCS = srt_pkg::MAX_PROCS_DEF,
    parameter int TIME_BITS = srt_pkg::TIME_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    srt_in_if.sink     i_in,
    srt_out_if.source  o_out
);
    import srt_pkg::*;

    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W = $clog2(MAX_PROCS + 1);
    localparam int CMP_W = (TIME_BITS > ARR_W) ? TIME_BITS : ARR_W;
    localparam int WIDE  = CMP_W + 1;
    localparam int SUM_X = ((WIDE > SUM_W) ? WIDE : SUM_W) + 1;
    localparam logic [IDX_W-1:0]     CNT_LAST = IDX_W'(MAX_PROCS - 1);
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
    localparam logic [SUM_W-1:0]     SUM_MAX  = '1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_APPLY  = 5'b00100,
        S_CALC   = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state               r_state;
    t_state               n_state;
    logic [IDX_W-1:0]     r_cnt;
    logic [KIND_W-1:0]    r_kind;
    logic [ARR_W-1:0]     r_arr;
    logic [BURST_W-1:0]   r_burst;
    logic [CNT_W-1:0]     r_loaded;
    logic [TIME_BITS-1:0] r_now;
    logic                 r_exh;
    logic [CNT_W-1:0]     r_last;
    logic [CNT_W-1:0]     r_done;
    logic [SUM_W-1:0]     r_tsum;
    logic [SUM_W-1:0]     r_wsum;
    logic [SUM_W-1:0]     n_tsum;
    logic [SUM_W-1:0]     n_wsum;
    t_status              r_status;
    logic [TIME_BITS-1:0] r_tick;
    logic [CNT_W-1:0]     r_id;
    logic                 r_sw;
    logic                 r_fin;
    logic [TIME_BITS-1:0] r_st;
    logic [WIDE-1:0]      r_en;
    logic [ARR_W-1:0]     r_warr;
    logic [BURST_W-1:0]   r_wburst;
    logic [WIDE-1:0]      r_ta;
    logic                 r_ovld;
    t_result              r_res;

    logic                 w_in_acc;
    logic                 w_out_free;
    logic                 w_full;
    t_cmd                 w_cmd;
    logic [IDX_W-1:0]     w_idx;
    t_cand                w_cand  [MAX_PROCS+1];
    logic [IDX_W-1:0]     w_cid   [MAX_PROCS+1];
    logic [TIME_BITS-1:0] w_cst   [MAX_PROCS+1];
    t_cand                w_win;
    logic [IDX_W-1:0]     w_win_id;
    logic [TIME_BITS-1:0] w_win_start;
    logic [CNT_W-1:0]     w_run_id;
    logic [WIDE-1:0]      w_wt;
    logic [SUM_X-1:0]     w_tsum_x;
    logic [SUM_X-1:0]     w_wsum_x;
    t_result              w_res;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_free = !r_ovld || o_out.ready;
    assign w_full     = (r_loaded == CNT_W'(MAX_PROCS));

    // Cell row: candidate enters empty at the head and leaves at the tail.
    assign w_cand[0] = '0;
    assign w_cid[0]  = '0;
    assign w_cst[0]  = '0;

    for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
        srt_cell #(
            .MAX_PROCS (MAX_PROCS),
            .TIME_BITS (TIME_BITS),
            .INDEX     (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_cmd_idx    (w_idx),
            .i_now        (r_now),
            .i_cand       (w_cand[g]),
            .i_cand_id    (w_cid[g]),
            .i_cand_start (w_cst[g]),
            .o_cand       (w_cand[g+1]),
            .o_cand_id    (w_cid[g+1]),
            .o_cand_start (w_cst[g+1])
        );
    end

    assign w_win       = w_cand[MAX_PROCS];
    assign w_win_id    = w_cid[MAX_PROCS];
    assign w_win_start = w_cst[MAX_PROCS];
    assign w_run_id    = CNT_W'(w_win_id) + CNT_W'(1);

    // Command to the cell row, issued in the apply cycle.
    always_comb begin
        w_cmd.op    = OP_NONE;
        w_cmd.arr   = r_arr;
        w_cmd.burst = r_burst;
        w_idx       = IDX_W'(r_loaded);
        if (r_state == S_APPLY) begin
            case (r_kind)
                KIND_LOAD: begin
                    if (!w_full) begin
                        w_cmd.op = OP_LOAD;
                    end
                end
                KIND_TICK: begin
                    if (!r_exh && w_win.vld) begin
                        w_cmd.op = OP_RUN;
                        w_idx    = w_win_id;
                    end
                end
                KIND_CLEAR: begin
                    w_cmd.op = OP_CLEAR;
                end
                default: ;
            endcase
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = (i_in.kind == KIND_TICK) ? S_SEARCH : S_APPLY;
                end
            end
            S_SEARCH: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY:  n_state = S_CALC;
            S_CALC:   n_state = S_FINISH;
            S_FINISH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Waiting time and saturating totals of a completed process.
    assign w_wt = (r_fin && (r_ta >= WIDE'(r_wburst))) ? r_ta - WIDE'(r_wburst) : '0;
    assign w_tsum_x = SUM_X'(r_tsum) + SUM_X'(r_ta);
    assign w_wsum_x = SUM_X'(r_wsum) + SUM_X'(w_wt);

    always_comb begin
        n_tsum = r_tsum;
        n_wsum = r_wsum;
        if (r_fin) begin
            n_tsum = (w_tsum_x > SUM_X'(SUM_MAX)) ? SUM_MAX : SUM_W'(w_tsum_x);
            n_wsum = (w_wsum_x > SUM_X'(SUM_MAX)) ? SUM_MAX : SUM_W'(w_wsum_x);
        end
    end

    // Scheduler state and result flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_loaded <= '0;
            r_now    <= '0;
            r_exh    <= 1'b0;
            r_last   <= '0;
            r_done   <= '0;
            r_tsum   <= '0;
            r_wsum   <= '0;
            r_status <= STAT_IDLE;
            r_id     <= '0;
            r_sw     <= 1'b0;
            r_fin    <= 1'b0;
            r_ovld   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (r_state == S_FINISH && w_out_free) begin
                r_ovld <= 1'b1;
            end else if (o_out.ready) begin
                r_ovld <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                end
                S_SEARCH: begin
                    r_cnt <= r_cnt + IDX_W'(1);
                end
                S_APPLY: begin
                    r_sw  <= 1'b0;
                    r_fin <= 1'b0;
                    r_id  <= '0;
                    case (r_kind)
                        KIND_LOAD: begin
                            if (w_full) begin
                                r_status <= STAT_FULL;
                            end else begin
                                r_status <= STAT_LOADED;
                                r_loaded <= r_loaded + CNT_W'(1);
                                r_id     <= r_loaded + CNT_W'(1);
                            end
                        end
                        KIND_TICK: begin
                            if (r_exh) begin
                                r_status <= STAT_EXHAUSTED;
                            end else begin
                                if (w_win.vld) begin
                                    r_status <= STAT_RAN;
                                    r_id     <= w_run_id;
                                    r_sw     <= (r_last != w_run_id);
                                    r_last   <= w_run_id;
                                    if (w_win.rem == BURST_W'(1)) begin
                                        r_fin  <= 1'b1;
                                        r_done <= r_done + CNT_W'(1);
                                    end
                                end else begin
                                    r_status <= STAT_IDLE;
                                end
                                if (r_now == TIME_MAX) begin
                                    r_exh <= 1'b1;
                                end else begin
                                    r_now <= r_now + TIME_BITS'(1);
                                end
                            end
                        end
                        KIND_CLEAR: begin
                            r_status <= STAT_CLEARED;
                            r_loaded <= '0;
                            r_now    <= '0;
                            r_exh    <= 1'b0;
                            r_last   <= '0;
                            r_done   <= '0;
                            r_tsum   <= '0;
                            r_wsum   <= '0;
                        end
                        default: begin
                            r_status <= STAT_IDLE;
                        end
                    endcase
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_tsum <= n_tsum;
                        r_wsum <= n_wsum;
                    end
                end
                default: ;
            endcase
        end
    end

    // Input capture and completion figures.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_kind  <= i_in.kind;
                    r_arr   <= i_in.arrival_time;
                    r_burst <= i_in.burst_length;
                end
            end
            S_APPLY: begin
                r_tick   <= r_now;
                r_st     <= w_win.started ? w_win_start : r_now;
                r_en     <= WIDE'(r_now) + WIDE'(1);
                r_warr   <= w_win.arr;
                r_wburst <= w_win.burst;
            end
            S_CALC: begin
                r_ta <= (r_fin && (r_en >= WIDE'(r_warr))) ? r_en - WIDE'(r_warr) : '0;
            end
            S_FINISH: begin
                if (w_out_free) begin
                    r_res <= w_res;
                end
            end
            default: ;
        endcase
    end

    // Result assembly.
    always_comb begin
        w_res.status           = r_status;
        w_res.tick_time        = TICK_W'(r_tick);
        w_res.proc_id          = ID_W'(r_id);
        w_res.switched         = r_sw;
        w_res.finished         = r_fin;
        w_res.start_time       = r_fin ? START_W'(r_st) : '0;
        w_res.end_time         = r_fin ? END_W'(r_en) : '0;
        w_res.turnaround       = TA_W'(r_ta);
        w_res.waiting          = WAIT_W'(w_wt);
        w_res.completed_count  = DONE_W'(r_done);
        w_res.total_turnaround = n_tsum;
        w_res.total_waiting    = n_wsum;
    end

    assign o_out.valid            = r_ovld;
    assign o_out.status           = r_res.status;
    assign o_out.tick_time        = r_res.tick_time;
    assign o_out.proc_id          = r_res.proc_id;
    assign o_out.switched         = r_res.switched;
    assign o_out.finished         = r_res.finished;
    assign o_out.start_time       = r_res.start_time;
    assign o_out.end_time         = r_res.end_time;
    assign o_out.turnaround       = r_res.turnaround;
    assign o_out.waiting          = r_res.waiting;
    assign o_out.completed_count  = r_res.completed_count;
    assign o_out.total_turnaround = r_res.total_turnaround;
    assign o_out.total_waiting    = r_res.total_waiting;

    // The table never holds more processes than it has cells.
    `AST_IMP(a_loaded_max, i_clk, i_rst_n, 1'b1, r_loaded <= CNT_W'(MAX_PROCS))
    // Time only stops once it has reached its largest value.
    `AST_IMP(a_exh_at_max, i_clk, i_rst_n, r_exh, r_now == TIME_MAX)
    // No more processes complete than were loaded.
    `AST_IMP(a_done_le_loaded, i_clk, i_rst_n, 1'b1, r_done <= r_loaded)
    // The sweep ends after the last cell and hands over to the update.
    `AST_NEXT(a_sweep_end, i_clk, i_rst_n, r_state == S_SEARCH && r_cnt == CNT_LAST, r_state == S_APPLY)

endmodule
